### hw/rtl/drtm_pkg.sv
package drtm_pkg;

   localparam int WORD_BITS     = 64;
   localparam int NUM_WORDS     = 4;
   localparam int DESC_BITS_DEF = NUM_WORDS * WORD_BITS;
   localparam int WCNT_W        = $clog2(WORD_BITS + 1);
   localparam int DIST_W        = 9;
   localparam int IDX_W         = 16;
   localparam int PROD_W        = 2 * DIST_W;
   localparam int Q8_SHIFT      = 8;
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 9;
   localparam int FIFO_DEPTH    = 4;
   localparam int PTR_W         = $clog2(FIFO_DEPTH);
   localparam int CNT_W         = $clog2(FIFO_DEPTH + 1);

   localparam logic [DIST_W-1:0] NO_DIST       = 9'd256;
   localparam logic [DIST_W-1:0] THRESHOLD_RST = 9'd50;
   localparam logic [DIST_W-1:0] RATIO_RST     = 9'd230;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_CAND = 1'b1
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_THRESHOLD = 2'd0,
      CSR_RATIO     = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic                 operation;
      logic [WORD_BITS-1:0] word0;
      logic [WORD_BITS-1:0] word1;
      logic [WORD_BITS-1:0] word2;
      logic [WORD_BITS-1:0] word3;
      logic [IDX_W-1:0]     item_index;
      logic                 query_active;
      logic                 excluded;
      logic                 last_candidate;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]  query_index;
      logic              match_found;
      logic [IDX_W-1:0]  best_index;
      logic [DIST_W-1:0] best_distance;
      logic [DIST_W-1:0] second_distance;
   } rsp_type;

   typedef struct packed {
      logic                              is_load;
      logic [IDX_W-1:0]                  item_index;
      logic                              query_active;
      logic                              excluded;
      logic                              last_candidate;
      logic [NUM_WORDS-1:0][WCNT_W-1:0]  counts;
   } cand_type;

   typedef struct packed {
      logic [DIST_W-1:0] threshold;
      logic [DIST_W-1:0] ratio;
   } cfg_type;

endpackage

### hw/rtl/drtm_dist.sv
module drtm_dist #(
   parameter int DESC_BITS = drtm_pkg::DESC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  drtm_pkg::req_type  in_data,
   output logic               s1_valid,
   output logic               cand_valid,
   output drtm_pkg::cand_type cand
);

   localparam int WB = drtm_pkg::WORD_BITS;
   localparam int NW = drtm_pkg::NUM_WORDS;

   function automatic logic [drtm_pkg::WCNT_W-1:0] popcount_word(input logic [WB-1:0] v);
      logic [drtm_pkg::WCNT_W-1:0] n;
      n = '0;
      for (int i = 0; i < WB; i++) begin
         n = n + drtm_pkg::WCNT_W'(v[i]);
      end
      return n;
   endfunction

   logic                     s1_valid_ff;
   drtm_pkg::req_type        s1_ff;
   logic [NW-1:0][WB-1:0]    query_ff;
   logic [NW-1:0][WB-1:0]    words_s1;
   logic [NW-1:0][WB-1:0]    desc_mask;
   logic                     cand_valid_ff;
   drtm_pkg::cand_type       cand_ff;
   drtm_pkg::cand_type       cand_in;

   // Only the low DESC_BITS bits of a descriptor take part in the distance.
   always_comb begin
      for (int w = 0; w < NW; w++) begin
         for (int b = 0; b < WB; b++) begin
            desc_mask[w][b] = ((w * WB + b) < DESC_BITS);
         end
      end
   end

   assign words_s1 = {s1_ff.word3, s1_ff.word2, s1_ff.word1, s1_ff.word0};

   always_comb begin
      cand_in.is_load        = (s1_ff.operation == drtm_pkg::OP_LOAD);
      cand_in.item_index     = s1_ff.item_index;
      cand_in.query_active   = s1_ff.query_active;
      cand_in.excluded       = s1_ff.excluded;
      cand_in.last_candidate = s1_ff.last_candidate;
      for (int w = 0; w < NW; w++) begin
         cand_in.counts[w] = popcount_word((words_s1[w] ^ query_ff[w]) & desc_mask[w]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         cand_valid_ff <= 1'b0;
         query_ff      <= '0;
      end else begin
         s1_valid_ff   <= in_valid;
         cand_valid_ff <= s1_valid_ff;
         // A load replaces the query here, so every later candidate in this
         // stage is scored against it.
         if (s1_valid_ff && (s1_ff.operation == drtm_pkg::OP_LOAD)) begin
            query_ff <= words_s1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid) begin
         s1_ff <= in_data;
      end
      if (s1_valid_ff) begin
         cand_ff <= cand_in;
      end
   end

   assign s1_valid   = s1_valid_ff;
   assign cand_valid = cand_valid_ff;
   assign cand       = cand_ff;

endmodule

### hw/rtl/drtm_select.sv
module drtm_select (
   input  logic               clock,
   input  logic               reset,
   input  logic               cand_valid,
   input  drtm_pkg::cand_type cand,
   input  drtm_pkg::cfg_type  cfg,
   output logic               push,
   output drtm_pkg::rsp_type  push_data
);

   localparam int DW = drtm_pkg::DIST_W;
   localparam int IW = drtm_pkg::IDX_W;
   localparam int PW = drtm_pkg::PROD_W;

   logic [IW-1:0] qidx_ff, qidx_in;
   logic          enabled_ff, enabled_in;
   logic          enabled_cur;
   logic [DW-1:0] best_ff, best_in;
   logic [DW-1:0] second_ff, second_in;
   logic [IW-1:0] bidx_ff, bidx_in;
   logic [DW-1:0] cand_dist;
   logic          emit;
   logic          seen;
   logic [PW-1:0] lhs;
   logic [PW-1:0] rhs;

   always_comb begin
      cand_dist = '0;
      for (int w = 0; w < drtm_pkg::NUM_WORDS; w++) begin
         cand_dist = cand_dist + DW'(cand.counts[w]);
      end
   end

   always_comb begin
      if (cand.is_load) begin
         qidx_in     = cand.item_index;
         enabled_cur = cand.query_active;
         best_in     = drtm_pkg::NO_DIST;
         second_in   = drtm_pkg::NO_DIST;
         bidx_in     = '0;
      end else begin
         qidx_in     = qidx_ff;
         enabled_cur = enabled_ff;
         best_in     = best_ff;
         second_in   = second_ff;
         bidx_in     = bidx_ff;
         // Ties never displace the best, so a distance of 256 never wins.
         if (!cand.excluded) begin
            if (cand_dist < best_ff) begin
               second_in = best_ff;
               best_in   = cand_dist;
               bidx_in   = cand.item_index;
            end else if (cand_dist < second_ff) begin
               second_in = cand_dist;
            end
         end
      end
      emit       = cand_valid && cand.last_candidate && enabled_cur;
      enabled_in = emit ? 1'b0 : enabled_cur;
   end

   always_comb begin
      seen = (best_in < drtm_pkg::NO_DIST);
      lhs  = PW'(best_in) << drtm_pkg::Q8_SHIFT;
      rhs  = PW'(cfg.ratio) * PW'(second_in);
      push_data.query_index     = qidx_in;
      push_data.match_found     = seen && (best_in <= cfg.threshold) && (lhs < rhs);
      push_data.best_index      = bidx_in;
      push_data.best_distance   = best_in;
      push_data.second_distance = second_in;
   end

   assign push = emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         qidx_ff    <= '0;
         enabled_ff <= 1'b0;
         best_ff    <= drtm_pkg::NO_DIST;
         second_ff  <= drtm_pkg::NO_DIST;
         bidx_ff    <= '0;
      end else if (cand_valid) begin
         qidx_ff    <= qidx_in;
         enabled_ff <= enabled_in;
         best_ff    <= best_in;
         second_ff  <= second_in;
         bidx_ff    <= bidx_in;
      end
   end

endmodule

### hw/rtl/drtm_fifo.sv
module drtm_fifo (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  drtm_pkg::rsp_type           push_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output drtm_pkg::rsp_type           rsp_data,
   output logic [drtm_pkg::CNT_W-1:0]  count
);

   localparam int DEPTH = drtm_pkg::FIFO_DEPTH;
   localparam int PW    = drtm_pkg::PTR_W;
   localparam int CW    = drtm_pkg::CNT_W;

   drtm_pkg::rsp_type entry_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              pop;

   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid && !rsp_stall;
   assign rsp_data  = entry_ff[rd_ptr_ff];
   assign count     = count_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### hw/rtl/descriptor_ratio_test_matcher_top.sv
// Port group  Direction  Handshake          Payload
// req_        in         req_valid/stall    drtm_pkg::req_type (load or candidate)
// rsp_        out        rsp_valid/stall    drtm_pkg::rsp_type (one per closed query)
// csr_        in         csr_valid/ready    csr_index, csr_data (threshold, ratio)
//
// One request is taken per cycle while req_stall is low; the request that closes
// a query reaches its result through the input register, the popcount register,
// then the result queue.
// The two distance registers are updated in one pass per cycle, so
// back-to-back candidates need no bubbles.
// Reset is synchronous; there is no clearing pass.
// req_stall rises when the requests in flight plus the queued results fill
// the four-entry result queue, so a stalled rsp_ side never drops a result.
module descriptor_ratio_test_matcher_top #(
   parameter int DESC_BITS = drtm_pkg::DESC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  drtm_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output drtm_pkg::rsp_type               rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [drtm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [drtm_pkg::CSR_DATA_W-1:0] csr_data
);

   localparam int CW = drtm_pkg::CNT_W;

   logic                    req_accept;
   logic                    s1_valid;
   logic                    cand_valid;
   drtm_pkg::cand_type      cand;
   logic                    push;
   drtm_pkg::rsp_type       push_data;
   logic [CW-1:0]           fifo_count;
   logic [CW-1:0]           in_flight;
   drtm_pkg::cfg_type       cfg_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold <= drtm_pkg::THRESHOLD_RST;
         cfg_ff.ratio     <= drtm_pkg::RATIO_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            drtm_pkg::CSR_THRESHOLD: cfg_ff.threshold <= csr_data;
            drtm_pkg::CSR_RATIO:     cfg_ff.ratio     <= csr_data;
            default: ;
         endcase
      end
   end

   // Every request in the pipe may still produce a result, so each holds a
   // queue slot until it has left the pipe.
   assign in_flight  = CW'(s1_valid) + CW'(cand_valid) + fifo_count;
   assign req_stall  = (in_flight >= CW'(drtm_pkg::FIFO_DEPTH));
   assign req_accept = req_valid && !req_stall;

   drtm_dist #(
      .DESC_BITS (DESC_BITS)
   ) u_dist (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_accept),
      .in_data    (req_data),
      .s1_valid   (s1_valid),
      .cand_valid (cand_valid),
      .cand       (cand)
   );

   drtm_select u_select (
      .clock      (clock),
      .reset      (reset),
      .cand_valid (cand_valid),
      .cand       (cand),
      .cfg        (cfg_ff),
      .push       (push),
      .push_data  (push_data)
   );

   drtm_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .count     (fifo_count)
   );

`ifndef SYNTHESIS
   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      in_flight <= CW'(drtm_pkg::FIFO_DEPTH))
      else $error("requests in flight exceed the result queue depth");

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      push |-> (fifo_count < CW'(drtm_pkg::FIFO_DEPTH)) || (rsp_valid && !rsp_stall))
      else $error("result pushed into a full queue");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> s1_valid)
      else $error("accepted request did not enter the pipe");

   a_dist_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.best_distance <= rsp_data.second_distance)
      else $error("best distance above second distance");

   a_match_sane: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.match_found) |->
         (rsp_data.best_distance != drtm_pkg::NO_DIST) &&
         (rsp_data.best_distance <= cfg_ff.threshold))
      else $error("match reported without a scored candidate under threshold");
`endif

endmodule

### tb/tb_descriptor_ratio_test_matcher_top.sv
module tb_descriptor_ratio_test_matcher_top;

   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE_CYCLES = 8;
   localparam int IDX_W = drtm_pkg::IDX_W;
   localparam int DIST_W = drtm_pkg::DIST_W;

   class ratio_match_board;
      logic [255:0]      query_bits;
      logic [IDX_W-1:0]  query_id;
      bit                query_open;
      logic [DIST_W-1:0] best_d;
      logic [DIST_W-1:0] second_d;
      logic [IDX_W-1:0]  best_id;
      logic [DIST_W-1:0] threshold;
      logic [DIST_W-1:0] ratio;
      drtm_pkg::rsp_type pending_matches[$];
      int                errors;

      function new();
         query_bits = '0;
         query_id = '0;
         query_open = 0;
         best_d = drtm_pkg::NO_DIST;
         second_d = drtm_pkg::NO_DIST;
         best_id = '0;
         threshold = drtm_pkg::THRESHOLD_RST;
         ratio = drtm_pkg::RATIO_RST;
         errors = 0;
      endfunction

      function void set_register(input drtm_pkg::csr_index_type idx,
                                 input logic [DIST_W-1:0] value);
         if (idx == drtm_pkg::CSR_THRESHOLD)
            threshold = value;
         else if (idx == drtm_pkg::CSR_RATIO)
            ratio = value;
      endfunction

      function void take_request(input drtm_pkg::req_type r);
         logic [255:0]      d;
         int                hd;
         drtm_pkg::rsp_type m;
         d = {r.word3, r.word2, r.word1, r.word0};
         if (r.operation == drtm_pkg::OP_LOAD) begin
            query_bits = d;
            query_id = r.item_index;
            query_open = r.query_active;
            best_d = drtm_pkg::NO_DIST;
            second_d = drtm_pkg::NO_DIST;
            best_id = '0;
         end else if (!r.excluded) begin
            hd = $countones(d ^ query_bits);
            if (hd < best_d) begin
               second_d = best_d;
               best_d = DIST_W'(hd);
               best_id = r.item_index;
            end else if (hd < second_d) begin
               second_d = DIST_W'(hd);
            end
         end
         if (r.last_candidate && query_open) begin
            m.query_index = query_id;
            m.match_found = (best_d < drtm_pkg::NO_DIST) && (best_d <= threshold) &&
                            (int'(best_d) * 256 < int'(ratio) * int'(second_d));
            m.best_index = best_id;
            m.best_distance = best_d;
            m.second_distance = second_d;
            pending_matches.push_back(m);
            query_open = 0;
         end
      endfunction

      task report(input string msg);
         $display("MISMATCH: %s", msg);
         errors++;
      endtask

      task check_match(input drtm_pkg::rsp_type got);
         drtm_pkg::rsp_type want;
         if (pending_matches.size() == 0) begin
            report($sformatf("result for query %0d with no request pending", got.query_index));
            return;
         end
         want = pending_matches.pop_front();
         if (got.query_index != want.query_index)
            report($sformatf("query_index %0d, expected %0d", got.query_index,
                             want.query_index));
         if (got.match_found != want.match_found)
            report($sformatf("query %0d match_found %0b, expected %0b", want.query_index,
                             got.match_found, want.match_found));
         if (got.best_index != want.best_index)
            report($sformatf("query %0d best_index %0d, expected %0d", want.query_index,
                             got.best_index, want.best_index));
         if (got.best_distance != want.best_distance)
            report($sformatf("query %0d best_distance %0d, expected %0d", want.query_index,
                             got.best_distance, want.best_distance));
         if (got.second_distance != want.second_distance)
            report($sformatf("query %0d second_distance %0d, expected %0d",
                             want.query_index, got.second_distance, want.second_distance));
      endtask
   endclass

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_stall;
   drtm_pkg::req_type               req_data;
   logic                            rsp_valid;
   logic                            rsp_stall;
   drtm_pkg::rsp_type               rsp_data;
   logic                            csr_valid;
   logic                            csr_ready;
   logic [drtm_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [drtm_pkg::CSR_DATA_W-1:0] csr_data;

   ratio_match_board board = new();
   int send_idle_pct;
   int recv_stall_pct;
   int cycle_count;

   descriptor_ratio_test_matcher_top DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("descriptor_ratio_test_matcher_top test failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_match(rsp_data);
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   function automatic logic [255:0] random_desc();
      int sel;
      sel = $urandom_range(19);
      if (sel == 0)
         return '0;
      if (sel == 1)
         return '1;
      return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
   endfunction

   function automatic logic [255:0] low_ones(input int n);
      logic [255:0] m;
      m = '0;
      for (int i = 0; i < n; i++)
         m[i] = 1'b1;
      return m;
   endfunction

   // Candidates mostly sit close to the query so that matches and near ties occur.
   function automatic logic [255:0] near_desc(input logic [255:0] qd);
      logic [255:0] flips;
      int           k;
      int           sel;
      flips = '0;
      sel = $urandom_range(9);
      if (sel < 2)
         return random_desc();
      k = (sel < 6) ? $urandom_range(12) : $urandom_range(80);
      for (int i = 0; i < k; i++)
         flips[$urandom_range(255)] = 1'b1;
      if (sel == 9)
         return ~qd ^ flips;
      return qd ^ flips;
   endfunction

   function automatic logic [IDX_W-1:0] pick_index();
      int sel;
      sel = $urandom_range(9);
      if (sel == 0)
         return '0;
      if (sel == 1)
         return '1;
      return IDX_W'($urandom_range(65535));
   endfunction

   // The flag is query_active on a load and excluded on a candidate; the other one is noise.
   function automatic drtm_pkg::req_type make_req(input drtm_pkg::op_type op,
                                                  input logic [255:0] d,
                                                  input logic [IDX_W-1:0] idx, input bit flag,
                                                  input bit last);
      drtm_pkg::req_type r;
      r.operation = op;
      r.word0 = d[63:0];
      r.word1 = d[127:64];
      r.word2 = d[191:128];
      r.word3 = d[255:192];
      r.item_index = idx;
      r.query_active = (op == drtm_pkg::OP_LOAD) ? flag : ($urandom_range(1) == 1);
      r.excluded = (op == drtm_pkg::OP_CAND) ? flag : ($urandom_range(1) == 1);
      r.last_candidate = last;
      return r;
   endfunction

   task automatic send_request(input drtm_pkg::req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do
         @(posedge clock);
      while (req_stall);
      board.take_request(r);
   endtask

   // Holds requests back until every result is in and the pipeline has emptied.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending_matches.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_settings(input logic [drtm_pkg::CSR_DATA_W-1:0] thr,
                                 input logic [drtm_pkg::CSR_DATA_W-1:0] rat);
      csr_valid <= 1'b1;
      csr_index <= drtm_pkg::CSR_THRESHOLD;
      csr_data <= thr;
      do
         @(posedge clock);
      while (!csr_ready);
      board.set_register(drtm_pkg::CSR_THRESHOLD, thr);
      csr_index <= drtm_pkg::CSR_RATIO;
      csr_data <= rat;
      do
         @(posedge clock);
      while (!csr_ready);
      board.set_register(drtm_pkg::CSR_RATIO, rat);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic run_directed();
      logic [255:0] qd;
      qd = random_desc();
      // A candidate before any load closes nothing.
      send_request(make_req(drtm_pkg::OP_CAND, qd, 16'd7, 1'b0, 1'b1));
      // Loads that close at once: enabled emits a no-match result, masked emits nothing.
      send_request(make_req(drtm_pkg::OP_LOAD, '0, 16'hFFFF, 1'b1, 1'b1));
      send_request(make_req(drtm_pkg::OP_LOAD, qd, 16'd3, 1'b0, 1'b1));
      // Exact hit at index 0, a fully different candidate, and two excluded candidates, the last one closing.
      send_request(make_req(drtm_pkg::OP_LOAD, '1, 16'd0, 1'b1, 1'b0));
      send_request(make_req(drtm_pkg::OP_CAND, '1, 16'd0, 1'b0, 1'b0));
      send_request(make_req(drtm_pkg::OP_CAND, '0, 16'hFFFF, 1'b0, 1'b0));
      send_request(make_req(drtm_pkg::OP_CAND, ~low_ones(10), 16'd5, 1'b1, 1'b0));
      send_request(make_req(drtm_pkg::OP_CAND, ~low_ones(100), 16'd9, 1'b1, 1'b1));
      // Equal distances: the first one stays best and the second one fills in.
      send_request(make_req(drtm_pkg::OP_LOAD, qd, 16'd1, 1'b1, 1'b0));
      send_request(make_req(drtm_pkg::OP_CAND, qd ^ low_ones(20), 16'd3, 1'b0, 1'b0));
      send_request(make_req(drtm_pkg::OP_CAND, qd ^ low_ones(20), 16'd4, 1'b0, 1'b0));
      send_request(make_req(drtm_pkg::OP_CAND, qd ^ low_ones(30), 16'd6, 1'b0, 1'b1));
      // Nothing scored.
      send_request(make_req(drtm_pkg::OP_LOAD, qd, 16'd2, 1'b1, 1'b0));
      send_request(make_req(drtm_pkg::OP_CAND, qd, 16'd8, 1'b1, 1'b1));
      // Masked query with candidates, then a candidate after the query closed.
      send_request(make_req(drtm_pkg::OP_LOAD, qd, 16'd4, 1'b0, 1'b0));
      send_request(make_req(drtm_pkg::OP_CAND, qd ^ low_ones(1), 16'd8, 1'b0, 1'b0));
      send_request(make_req(drtm_pkg::OP_CAND, qd, 16'd9, 1'b0, 1'b1));
      send_request(make_req(drtm_pkg::OP_CAND, qd, 16'd10, 1'b0, 1'b1));
      // A distance of 256 never becomes the best.
      send_request(make_req(drtm_pkg::OP_LOAD, qd, 16'd5, 1'b1, 1'b0));
      send_request(make_req(drtm_pkg::OP_CAND, ~qd, 16'd1, 1'b0, 1'b1));
      // Best equal to the threshold, ratio test passing by a hair.
      send_request(make_req(drtm_pkg::OP_LOAD, qd, 16'd6, 1'b1, 1'b0));
      send_request(make_req(drtm_pkg::OP_CAND, qd ^ low_ones(50), 16'd2, 1'b0, 1'b0));
      send_request(make_req(drtm_pkg::OP_CAND, qd ^ low_ones(56), 16'd3, 1'b0, 1'b1));
   endtask

   task automatic run_random(input int target);
      int           sent;
      int           n_cand;
      int           sel;
      bit           active;
      bit           closes;
      logic [255:0] qd;
      sent = 0;
      while (sent < target) begin
         sel = $urandom_range(99);
         qd = random_desc();
         if (sel < 8) begin
            // Stray candidate: it may close an open query or land on a closed one.
            send_request(make_req(drtm_pkg::OP_CAND, qd, pick_index(),
                                  $urandom_range(3) == 0, $urandom_range(1) == 1));
            sent++;
         end else begin
            active = ($urandom_range(9) != 0);
            n_cand = (sel < 14) ? 0 : (sel < 94) ? $urandom_range(8, 1) : $urandom_range(24, 9);
            send_request(make_req(drtm_pkg::OP_LOAD, qd, pick_index(), active, n_cand == 0));
            sent++;
            for (int i = 0; i < n_cand; i++) begin
               // A few sequences are cut short and left to the next load.
               closes = (i == n_cand - 1) && ($urandom_range(19) != 0);
               send_request(make_req(drtm_pkg::OP_CAND, near_desc(qd), pick_index(),
                                     $urandom_range(6) == 0, closes));
               sent++;
            end
         end
      end
   endtask

   initial begin
      int thr_list[6];
      int ratio_list[6];
      thr_list = '{256, 0, 511, 100, 300, 20};
      ratio_list = '{256, 0, 511, 200, 128, 255};
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      cycle_count = 0;
      send_idle_pct = 7;
      recv_stall_pct = 78;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();
      drain();
      for (int p = 0; p < 6; p++) begin
         if (p < 2) begin
            send_idle_pct = 7;
            recv_stall_pct = 78;
         end else if (p < 4) begin
            send_idle_pct = 78;
            recv_stall_pct = 7;
         end else begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end
         write_settings(drtm_pkg::CSR_DATA_W'(thr_list[p]),
                        drtm_pkg::CSR_DATA_W'(ratio_list[p]));
         run_random(100);
         drain();
      end

      if (board.errors == 0)
         $display("descriptor_ratio_test_matcher_top test passed");
      else
         $display("descriptor_ratio_test_matcher_top test failed");
      $finish;
   end

endmodule

### sim.f
hw/rtl/drtm_pkg.sv
hw/rtl/drtm_dist.sv
hw/rtl/drtm_select.sv
hw/rtl/drtm_fifo.sv
hw/rtl/descriptor_ratio_test_matcher_top.sv
tb/tb_descriptor_ratio_test_matcher_top.sv
